@@ src/fitness_rank_sort_with_elitism_macros.svh @@
// Assertion helpers for the rank sort sequencer.
`ifndef FITNESS_RANK_SORT_WITH_ELITISM_MACROS_SVH
`define FITNESS_RANK_SORT_WITH_ELITISM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/frs_pkg.sv @@
`timescale 1ns / 1ps

package frs_pkg;

    localparam int FIT_W  = 32;
    localparam int GENE_W = 20;
    localparam int IDX_W  = 6;

    typedef struct packed {
        logic signed [FIT_W-1:0]  fit_value;
        logic        [GENE_W-1:0] gene_bits;
        logic                     final_entry;
    } t_in_item;

    typedef struct packed {
        logic        [IDX_W-1:0]  rank_pos;
        logic        [IDX_W-1:0]  origin_index;
        logic signed [FIT_W-1:0]  rank_fitness;
        logic        [GENE_W-1:0] rank_gene;
        logic                     elite_copy;
        logic                     end_of_list;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT_KEY,
        ST_EMIT_SRC,
        ST_EMIT_OUT
    } t_state;

endpackage

@@ src/frs_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port memory: one write port, one read port with registered data.
// The read data holds its value while no read is issued.
module frs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/frs_ctrl.sv @@
`timescale 1ns / 1ps

`include "fitness_rank_sort_with_elitism_macros.svh"

// Sequencer for loading, the exchange sort over the key memory, and the
// ranked emission with elite replacement.
module frs_ctrl #(
    parameter int MAX_POPULATION = 64,
    parameter int GENE_BITS      = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  frs_pkg::t_in_item          i_in_item,
    // Output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output frs_pkg::t_out_item         o_out_item,
    // Entry memory (fitness and gene).
    output logic                       o_ent_we,
    output logic [$clog2(MAX_POPULATION)-1:0] o_ent_waddr,
    output logic [frs_pkg::FIT_W+((GENE_BITS < frs_pkg::GENE_W) ? GENE_BITS :
                  frs_pkg::GENE_W)-1:0] o_ent_wdata,
    output logic                       o_ent_re,
    output logic [$clog2(MAX_POPULATION)-1:0] o_ent_raddr,
    input  logic [frs_pkg::FIT_W+((GENE_BITS < frs_pkg::GENE_W) ? GENE_BITS :
                  frs_pkg::GENE_W)-1:0] i_ent_rdata,
    // Key memory (rank order as load positions).
    output logic                       o_key_we,
    output logic [$clog2(MAX_POPULATION)-1:0] o_key_waddr,
    output logic [$clog2(MAX_POPULATION)-1:0] o_key_wdata,
    output logic                       o_key_re,
    output logic [$clog2(MAX_POPULATION)-1:0] o_key_raddr,
    input  logic [$clog2(MAX_POPULATION)-1:0] i_key_rdata
);

    import frs_pkg::*;

    localparam int AW  = $clog2(MAX_POPULATION);
    localparam int CW  = $clog2(MAX_POPULATION + 1);
    localparam int CEW = CW + 1;
    localparam int GW  = (GENE_BITS < GENE_W) ? GENE_BITS : GENE_W;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_n, n_n;
    logic [AW-1:0]       r_i, n_i;
    logic [AW-1:0]       r_j, n_j;
    logic [AW-1:0]       r_k, n_k;
    logic                r_p1_vld, n_p1_vld;
    logic                r_p1_first, n_p1_first;
    logic [AW-1:0]       r_p1_j, n_p1_j;
    logic                r_p2_vld, n_p2_vld;
    logic                r_p2_first, n_p2_first;
    logic [AW-1:0]       r_p2_j, n_p2_j;
    logic [AW-1:0]       r_p2_key, n_p2_key;
    logic [AW-1:0]       r_cur_key, n_cur_key;
    logic signed [FIT_W-1:0] r_cur_fit, n_cur_fit;
    logic [AW-1:0]       r_best, n_best;
    logic [AW-1:0]       r_src, n_src;
    logic                r_elite, n_elite;
    logic                r_out_vld, n_out_vld;
    t_out_item           r_out_item, n_out_item;

    logic signed [FIT_W-1:0] rd_fit;
    logic                    emit_elite;

    assign rd_fit     = i_ent_rdata[FIT_W+GW-1 -: FIT_W];
    assign emit_elite = (CEW'(r_n) >= CEW'(3)) &&
                        ((CEW'(r_k) + CEW'(2)) >= CEW'(r_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_p1_vld  <= n_p1_vld;
            r_p2_vld  <= n_p2_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_p1_first <= n_p1_first;
        r_p1_j     <= n_p1_j;
        r_p2_first <= n_p2_first;
        r_p2_j     <= n_p2_j;
        r_p2_key   <= n_p2_key;
        r_cur_key  <= n_cur_key;
        r_cur_fit  <= n_cur_fit;
        r_best     <= n_best;
        r_src      <= n_src;
        r_elite    <= n_elite;
        r_out_item <= n_out_item;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_p1_vld   = 1'b0;
        n_p1_first = r_p1_first;
        n_p1_j     = r_p1_j;
        n_p2_vld   = r_p1_vld;
        n_p2_first = r_p1_first;
        n_p2_j     = r_p1_j;
        n_p2_key   = i_key_rdata;
        n_cur_key  = r_cur_key;
        n_cur_fit  = r_cur_fit;
        n_best     = r_best;
        n_src      = r_src;
        n_elite    = r_elite;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_item = r_out_item;

        o_in_ready  = 1'b0;
        o_ent_we    = 1'b0;
        o_ent_waddr = r_count[AW-1:0];
        o_ent_wdata = {i_in_item.fit_value, i_in_item.gene_bits[GW-1:0]};
        o_ent_re    = 1'b0;
        o_ent_raddr = i_key_rdata;
        o_key_we    = 1'b0;
        o_key_waddr = r_count[AW-1:0];
        o_key_wdata = r_count[AW-1:0];
        o_key_re    = 1'b0;
        o_key_raddr = r_j;

        // Sort pipeline: the key read returns, so fetch that entry's fitness.
        if (r_p1_vld) begin
            o_ent_re    = 1'b1;
            o_ent_raddr = i_key_rdata;
        end

        // Sort pipeline: compare stage. The first entry of a pass seeds the
        // running key; a strictly greater later entry swaps with it.
        if (r_p2_vld) begin
            if (r_p2_first) begin
                n_cur_key = r_p2_key;
                n_cur_fit = rd_fit;
            end else if (r_cur_fit < rd_fit) begin
                o_key_we    = 1'b1;
                o_key_waddr = r_p2_j;
                o_key_wdata = r_cur_key;
                n_cur_key   = r_p2_key;
                n_cur_fit   = rd_fit;
            end
        end

        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_count < CW'(MAX_POPULATION)) begin
                        o_ent_we = 1'b1;
                        o_key_we = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                    if (i_in_item.final_entry) begin
                        n_n     = (r_count < CW'(MAX_POPULATION)) ?
                                  r_count + CW'(1) : r_count;
                        n_count = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_best  = '0;
                        if (n_n >= CW'(2)) begin
                            n_state = ST_ISSUE;
                        end else begin
                            n_state = ST_EMIT_KEY;
                        end
                    end
                end
            end
            ST_ISSUE: begin
                o_key_re    = 1'b1;
                o_key_raddr = r_j;
                n_p1_vld    = 1'b1;
                n_p1_first  = (r_j == r_i);
                n_p1_j      = r_j;
                if ((CW'(r_j) + CW'(1)) == r_n) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    o_key_we    = 1'b1;
                    o_key_waddr = r_i;
                    o_key_wdata = r_cur_key;
                    if (r_i == '0) begin
                        n_best = r_cur_key;
                    end
                    if ((CW'(r_i) + CW'(2)) == r_n) begin
                        n_k     = '0;
                        n_state = ST_EMIT_KEY;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_j     = r_i + AW'(1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_EMIT_KEY: begin
                o_key_re    = 1'b1;
                o_key_raddr = r_k;
                n_state     = ST_EMIT_SRC;
            end
            ST_EMIT_SRC: begin
                n_elite     = emit_elite;
                n_src       = emit_elite ? r_best : i_key_rdata;
                o_ent_re    = 1'b1;
                o_ent_raddr = n_src;
                n_state     = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld               = 1'b1;
                    n_out_item.rank_pos     = IDX_W'(r_k);
                    n_out_item.origin_index = IDX_W'(r_src);
                    n_out_item.rank_fitness = rd_fit;
                    n_out_item.rank_gene    = GENE_W'(i_ent_rdata[GW-1:0]);
                    n_out_item.elite_copy   = r_elite;
                    n_out_item.end_of_list  = ((CW'(r_k) + CW'(1)) == r_n);
                    if ((CW'(r_k) + CW'(1)) == r_n) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = ST_EMIT_KEY;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    `FRS_ASSERT_IMP(a_pipe_in_sort, i_clk, i_rst_n, (r_p1_vld || r_p2_vld), ((r_state == ST_ISSUE) || (r_state == ST_DRAIN)), "sort pipeline busy outside the sort")
    `FRS_ASSERT_NEXT(a_pipe_advance, i_clk, i_rst_n, r_p1_vld, r_p2_vld, "sort pipeline lost an entry")
    `FRS_ASSERT_IMP(a_key_no_overlap, i_clk, i_rst_n, (o_key_we && o_key_re), (o_key_waddr != o_key_raddr), "key write and read hit the same entry")
    `FRS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, (r_count <= CW'(MAX_POPULATION)), "load count above capacity")
    `FRS_ASSERT_IMP(a_issue_range, i_clk, i_rst_n, (r_state == ST_ISSUE), ((r_n >= CW'(2)) && (CW'(r_j) < r_n)), "sort index outside the population")

endmodule

@@ src/fitness_rank_sort_with_elitism.sv @@
`timescale 1ns / 1ps

// Load: items are accepted at one item per cycle while loading; items past MAX_POPULATION
// are accepted but not stored. After the final item, the entries are exchange sorted, one
// compare per cycle through the key and entry memory read ports, with a drain between passes;
// then each result passes the key read, entry read and output register steps. No new item
// is accepted until the last result of the list has been registered for output.
// Reset clears the sequencer, the load count and the valid flags; memories keep their data.
module fitness_rank_sort_with_elitism #(
    parameter int MAX_POPULATION = 64,
    parameter int GENE_BITS      = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  frs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output frs_pkg::t_out_item o_out_item
);

    import frs_pkg::*;

    localparam int AW = $clog2(MAX_POPULATION);
    localparam int GW = (GENE_BITS < GENE_W) ? GENE_BITS : GENE_W;
    localparam int EW = FIT_W + GW;

    // Entry memory: each loaded item's fitness and gene, at its load position.
    logic          ent_we;
    logic [AW-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata;
    logic          ent_re;
    logic [AW-1:0] ent_raddr;
    logic [EW-1:0] ent_rdata;

    // Key memory: the load position held at each rank. Loading writes the
    // identity order, and the exchange sort rewrites it in place.
    logic          key_we;
    logic [AW-1:0] key_waddr;
    logic [AW-1:0] key_wdata;
    logic          key_re;
    logic [AW-1:0] key_raddr;
    logic [AW-1:0] key_rdata;

    frs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POPULATION)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    frs_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_POPULATION)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // The sequencer streams one key per cycle through a two-stage read
    // pipeline (key, then fitness) and keeps the running best of each pass
    // in registers. Swaps write back only the compared slot, which is never
    // read again in the same pass, so no forwarding is needed; a short drain
    // between passes keeps later passes from reading stale keys.
    frs_ctrl #(
        .MAX_POPULATION (MAX_POPULATION),
        .GENE_BITS      (GENE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ent_we    (ent_we),
        .o_ent_waddr (ent_waddr),
        .o_ent_wdata (ent_wdata),
        .o_ent_re    (ent_re),
        .o_ent_raddr (ent_raddr),
        .i_ent_rdata (ent_rdata),
        .o_key_we    (key_we),
        .o_key_waddr (key_waddr),
        .o_key_wdata (key_wdata),
        .o_key_re    (key_re),
        .o_key_raddr (key_raddr),
        .i_key_rdata (key_rdata)
    );

endmodule
